[rtl/core/tsgd_pkg.sv]
// tsgd_pkg: shared types and constants for the touch sweep gesture detector
// no dependencies

package tsgd_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int VALUE_W     = 16;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int MODE_W      = 3;
    localparam int STAGE_W     = 2;
    localparam int EXT_W       = (COORD_WIDTH > VALUE_W) ? COORD_WIDTH : VALUE_W;
    localparam int CMP_W       = ((COORD_WIDTH > CFG_W + 1) ? COORD_WIDTH : CFG_W + 1) + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SLOT  = 3'd0,
        MODE_TRACK = 3'd1,
        MODE_X     = 3'd2,
        MODE_Y     = 3'd3,
        MODE_OTHER = 3'd4
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LEFT_END = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MID_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MID_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_FLOOR    = 3'd4;

    localparam logic [CFG_W-1:0] RST_X_SPAN     = 12'd1280;
    localparam logic [CFG_W-1:0] RST_X_LEFT_END = 12'd266;
    localparam logic [CFG_W-1:0] RST_X_MID_LOW  = 12'd466;
    localparam logic [CFG_W-1:0] RST_X_MID_HIGH = 12'd800;
    localparam logic [CFG_W-1:0] RST_Y_FLOOR    = 12'd1800;

    localparam logic [VALUE_W-1:0] TRACK_RELEASE = 16'hFFFF;
    localparam logic [STAGE_W-1:0] STAGE_DONE    = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_BAD     = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] x_span;
        logic [CFG_W-1:0] x_left_end;
        logic [CFG_W-1:0] x_mid_low;
        logic [CFG_W-1:0] x_mid_high;
        logic [CFG_W-1:0] y_floor;
    } t_cfg;

    typedef struct packed {
        logic               power_press;
        logic [STAGE_W-1:0] stage;
    } t_res;

endpackage

[rtl/core/touch_sweep_gesture_detect.sv]
// touch_sweep_gesture_detect: top level, input register, result register, handshakes
// depends on tsgd_pkg, tsgd_cfg, tsgd_eval

// Each accepted touch event gives exactly one result item, and one event can be taken
// every cycle while the output side is ready. An event is held in the input register,
// evaluated against the gesture state in a single pass of compares, and its result
// lands in the output register, which lets the next event enter while a result still
// waits. Slot changes and finger releases clear the zone flags; an X and a Y position
// together trigger the zone check. Stage counts the zones passed in the current touch;
// power_press pulses once per touch. The user must write registers only while the
// block is idle; the block itself does not enforce this. Config ready is always high.

module touch_sweep_gesture_detect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tsgd_pkg::MODE_W-1:0]    i_mode,
    input  logic [tsgd_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_power_press,
    output logic [tsgd_pkg::STAGE_W-1:0]   o_stage,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tsgd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tsgd_pkg::CFG_W-1:0]     i_cfg_data
);

    logic                          r_in_valid;
    logic [tsgd_pkg::MODE_W-1:0]    r_in_mode;
    logic [tsgd_pkg::VALUE_W-1:0]   r_in_value;
    logic                          r_out_valid;
    tsgd_pkg::t_res                r_out;
    tsgd_pkg::t_res                res;
    tsgd_pkg::t_cfg                cfg;
    logic                          out_free;
    logic                          adv;
    logic                          in_acc;

    assign out_free    = !r_out_valid || i_ready;
    assign adv         = r_in_valid && out_free;
    assign o_ready     = !r_in_valid || out_free;
    assign in_acc      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    tsgd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tsgd_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_mode  (r_in_mode),
        .i_value (r_in_value),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_mode  <= i_mode;
            r_in_value <= i_value;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_power_press = r_out.power_press;
    assign o_stage       = r_out.stage;

    a_press_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_power_press) |-> (o_stage == tsgd_pkg::STAGE_DONE))
        else $error("power press without both zones passed");

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_stage != tsgd_pkg::STAGE_BAD))
        else $error("stage out of range");

    a_slot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (tsgd_pkg::t_mode'(r_in_mode) == tsgd_pkg::MODE_SLOT))
        |=> (o_valid && !o_power_press && (o_stage == '0)))
        else $error("slot change did not clear the gesture");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

endmodule

[rtl/core/tsgd_cfg.sv]
// tsgd_cfg: configuration register file for the zone edges and band floor
// depends on tsgd_pkg

module tsgd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [tsgd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tsgd_pkg::CFG_W-1:0]     i_cfg_data,
    output tsgd_pkg::t_cfg                o_cfg
);

    tsgd_pkg::t_cfg r_cfg;
    tsgd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tsgd_pkg::CFG_X_SPAN:     n_cfg.x_span     = i_cfg_data;
                tsgd_pkg::CFG_X_LEFT_END: n_cfg.x_left_end = i_cfg_data;
                tsgd_pkg::CFG_X_MID_LOW:  n_cfg.x_mid_low  = i_cfg_data;
                tsgd_pkg::CFG_X_MID_HIGH: n_cfg.x_mid_high = i_cfg_data;
                tsgd_pkg::CFG_Y_FLOOR:    n_cfg.y_floor    = i_cfg_data;
                default:                  n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_span     <= tsgd_pkg::RST_X_SPAN;
            r_cfg.x_left_end <= tsgd_pkg::RST_X_LEFT_END;
            r_cfg.x_mid_low  <= tsgd_pkg::RST_X_MID_LOW;
            r_cfg.x_mid_high <= tsgd_pkg::RST_X_MID_HIGH;
            r_cfg.y_floor    <= tsgd_pkg::RST_Y_FLOOR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/tsgd_eval.sv]
// tsgd_eval: gesture state (held coordinates, zone flags, arm) and zone compares
// depends on tsgd_pkg

module tsgd_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [tsgd_pkg::MODE_W-1:0]    i_mode,
    input  logic [tsgd_pkg::VALUE_W-1:0]   i_value,
    input  tsgd_pkg::t_cfg                i_cfg,
    output tsgd_pkg::t_res                o_res
);

    logic signed [tsgd_pkg::COORD_WIDTH-1:0] r_held_x, n_held_x;
    logic signed [tsgd_pkg::COORD_WIDTH-1:0] r_held_y, n_held_y;
    logic r_x_seen, n_x_seen;
    logic r_y_seen, n_y_seen;
    logic r_first, n_first;
    logic r_second, n_second;
    logic r_armed, n_armed;
    logic fire;

    logic signed [tsgd_pkg::EXT_W-1:0] value_ext;
    logic signed [tsgd_pkg::CMP_W-1:0] x_c, y_c, right_top, mid_hi, mid_lo, left_end, floor_c;
    logic is_clear, low_band, zone1, zone2, zone3;

    assign value_ext = tsgd_pkg::EXT_W'($signed(i_value));
    assign is_clear  = (tsgd_pkg::t_mode'(i_mode) == tsgd_pkg::MODE_SLOT)
                    || ((tsgd_pkg::t_mode'(i_mode) == tsgd_pkg::MODE_TRACK)
                        && (i_value == tsgd_pkg::TRACK_RELEASE));

    assign mid_hi    = tsgd_pkg::CMP_W'($signed({1'b0, i_cfg.x_mid_high}));
    assign mid_lo    = tsgd_pkg::CMP_W'($signed({1'b0, i_cfg.x_mid_low}));
    assign left_end  = tsgd_pkg::CMP_W'($signed({1'b0, i_cfg.x_left_end}));
    assign floor_c   = tsgd_pkg::CMP_W'($signed({1'b0, i_cfg.y_floor}));
    assign right_top = tsgd_pkg::CMP_W'($signed({1'b0, i_cfg.x_span})) - left_end;

    // compares on the coordinates as they stand after this item
    assign x_c      = tsgd_pkg::CMP_W'(n_held_x);
    assign y_c      = tsgd_pkg::CMP_W'(n_held_y);
    assign low_band = y_c > floor_c;
    assign zone1    = (x_c < right_top) && (x_c > mid_hi) && low_band;
    assign zone2    = (x_c < mid_hi) && (x_c > mid_lo) && low_band;
    assign zone3    = (x_c < mid_lo) && (x_c < left_end) && low_band;

    always_comb begin
        n_held_x = r_held_x;
        n_held_y = r_held_y;
        n_x_seen = r_x_seen;
        n_y_seen = r_y_seen;
        n_first  = r_first;
        n_second = r_second;
        n_armed  = r_armed;
        fire     = 1'b0;
        if (is_clear) begin
            n_first  = 1'b0;
            n_second = 1'b0;
            n_armed  = 1'b1;
        end else begin
            if (tsgd_pkg::t_mode'(i_mode) == tsgd_pkg::MODE_X) begin
                n_held_x = value_ext[tsgd_pkg::COORD_WIDTH-1:0];
                n_x_seen = 1'b1;
            end
            if (tsgd_pkg::t_mode'(i_mode) == tsgd_pkg::MODE_Y) begin
                n_held_y = value_ext[tsgd_pkg::COORD_WIDTH-1:0];
                n_y_seen = 1'b1;
            end
            if (n_x_seen && n_y_seen) begin
                n_x_seen = 1'b0;
                n_y_seen = 1'b0;
                if (r_first || zone1) begin
                    n_first = 1'b1;
                    if (r_second || zone2) begin
                        n_second = 1'b1;
                        if (zone3 && r_armed) begin
                            fire    = 1'b1;
                            n_armed = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
            r_x_seen <= 1'b0;
            r_y_seen <= 1'b0;
            r_first  <= 1'b0;
            r_second <= 1'b0;
            r_armed  <= 1'b1;
        end else if (i_adv) begin
            r_held_x <= n_held_x;
            r_held_y <= n_held_y;
            r_x_seen <= n_x_seen;
            r_y_seen <= n_y_seen;
            r_first  <= n_first;
            r_second <= n_second;
            r_armed  <= n_armed;
        end
    end

    assign o_res.power_press = fire;
    assign o_res.stage       = tsgd_pkg::STAGE_W'(n_first) + tsgd_pkg::STAGE_W'(n_second);

endmodule

[verif/touch_sweep_gesture_detect_tb.sv]
// touch_sweep_gesture_detect_tb: self-checking bench for the swipe gesture detector
// drives touch events and register writes over valid/ready, predicts press and stage
// depends on tsgd_pkg and touch_sweep_gesture_detect
`timescale 1ns / 100ps

module touch_sweep_gesture_detect_tb;
    import tsgd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_TOP = 3'd7;

    typedef enum logic [1:0] {ENT_EVENT, ENT_CFG, ENT_PHASE} t_ent_kind;

    typedef struct {
        t_ent_kind            kind;
        logic [MODE_W-1:0]    mode;
        logic [VALUE_W-1:0]   value;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        int                   send_pct;
        int                   recv_pct;
    } t_ent;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [MODE_W-1:0]    i_mode      = '0;
    logic [VALUE_W-1:0]   i_value     = '0;
    logic                 i_ready     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_power_press;
    logic [STAGE_W-1:0]   o_stage;
    logic                 o_cfg_ready;

    t_ent pend_q[$];
    t_res press_stage_q[$];

    // predictor state
    t_cfg zone_cfg = '{RST_X_SPAN, RST_X_LEFT_END, RST_X_MID_LOW, RST_X_MID_HIGH, RST_Y_FLOOR};
    logic signed [COORD_WIDTH-1:0] held_x = '0;
    logic signed [COORD_WIDTH-1:0] held_y = '0;
    logic x_seen = 1'b0;
    logic y_seen = 1'b0;
    logic first_passed = 1'b0;
    logic second_passed = 1'b0;
    logic armed = 1'b1;

    // stimulus-side copy of the registers, used to aim points into the zones
    t_cfg plan_cfg = '{RST_X_SPAN, RST_X_LEFT_END, RST_X_MID_LOW, RST_X_MID_HIGH, RST_Y_FLOOR};

    int send_idle = 28;
    int recv_idle = 83;
    int ev_total  = 0;
    int fail_cnt  = 0;
    int n_events  = 0;
    int n_cfg     = 0;
    int n_results = 0;
    int n_press   = 0;

    touch_sweep_gesture_detect u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_power_press(o_power_press),
        .o_stage      (o_stage),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic sweep_predict(input logic [MODE_W-1:0] ev_mode,
                                 input logic [VALUE_W-1:0] ev_value);
        logic signed [31:0] wide;
        int   x, y, right_top, mid_hi, mid_lo;
        logic low_band, fired;
        t_res r;
        wide  = 32'(signed'(ev_value));
        fired = 1'b0;
        if (ev_mode == MODE_SLOT || (ev_mode == MODE_TRACK && ev_value == TRACK_RELEASE)) begin
            armed         = 1'b1;
            first_passed  = 1'b0;
            second_passed = 1'b0;
        end else begin
            if (ev_mode == MODE_X) begin
                held_x = wide[COORD_WIDTH-1:0];
                x_seen = 1'b1;
            end
            if (ev_mode == MODE_Y) begin
                held_y = wide[COORD_WIDTH-1:0];
                y_seen = 1'b1;
            end
            if (x_seen && y_seen) begin
                x_seen    = 1'b0;
                y_seen    = 1'b0;
                x         = held_x;
                y         = held_y;
                right_top = int'(zone_cfg.x_span) - int'(zone_cfg.x_left_end);
                mid_hi    = int'(zone_cfg.x_mid_high);
                mid_lo    = int'(zone_cfg.x_mid_low);
                low_band  = (y > int'(zone_cfg.y_floor));
                if (first_passed || (x < right_top && x > mid_hi && low_band)) begin
                    first_passed = 1'b1;
                    if (second_passed || (x < mid_hi && x > mid_lo && low_band)) begin
                        second_passed = 1'b1;
                        if (x < mid_lo && low_band && x < int'(zone_cfg.x_left_end) && armed)
                        begin
                            fired = 1'b1;
                            armed = 1'b0;
                        end
                    end
                end
            end
        end
        r.power_press = fired;
        r.stage       = {1'b0, first_passed} + {1'b0, second_passed};
        press_stage_q.push_back(r);
    endtask

    task automatic queue_event(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
        t_ent e;
        e.kind     = ENT_EVENT;
        e.mode     = mode;
        e.value    = value;
        e.idx      = '0;
        e.data     = '0;
        e.send_pct = 0;
        e.recv_pct = 0;
        pend_q.push_back(e);
        ev_total++;
    endtask

    task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_ent e;
        e.kind     = ENT_CFG;
        e.mode     = '0;
        e.value    = '0;
        e.idx      = idx;
        e.data     = data;
        e.send_pct = 0;
        e.recv_pct = 0;
        pend_q.push_back(e);
        case (idx)
            CFG_X_SPAN:     plan_cfg.x_span     = data;
            CFG_X_LEFT_END: plan_cfg.x_left_end = data;
            CFG_X_MID_LOW:  plan_cfg.x_mid_low  = data;
            CFG_X_MID_HIGH: plan_cfg.x_mid_high = data;
            CFG_Y_FLOOR:    plan_cfg.y_floor    = data;
            default: ;
        endcase
    endtask

    task automatic queue_cfg_set(input logic [CFG_W-1:0] span, input logic [CFG_W-1:0] left_end,
                                 input logic [CFG_W-1:0] mid_low, input logic [CFG_W-1:0] mid_high,
                                 input logic [CFG_W-1:0] floor_y);
        queue_cfg(CFG_X_SPAN, span);
        queue_cfg(CFG_X_LEFT_END, left_end);
        queue_cfg(CFG_X_MID_LOW, mid_low);
        queue_cfg(CFG_X_MID_HIGH, mid_high);
        queue_cfg(CFG_Y_FLOOR, floor_y);
    endtask

    function automatic int zone_pick(input int lo, input int hi);
        if (hi - lo >= 2)
            return lo + 1 + int'($urandom_range(0, hi - lo - 2));
        return int'($urandom_range(0, 4095));
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        logic ev_take, cfg_take, nv, ncv;
        logic [MODE_W-1:0]    nmode;
        logic [VALUE_W-1:0]   nval;
        logic [CFG_IDX_W-1:0] nidx;
        logic [CFG_W-1:0]     ndata;
        ev_take  = i_valid && o_ready;
        cfg_take = i_cfg_valid && o_cfg_ready;
        nv       = i_valid && !ev_take;
        ncv      = i_cfg_valid && !cfg_take;
        nmode    = i_mode;
        nval     = i_value;
        nidx     = i_cfg_index;
        ndata    = i_cfg_data;
        if (!i_rst_n) begin
            nv  = 1'b0;
            ncv = 1'b0;
        end else begin
            if (ev_take) begin
                sweep_predict(i_mode, i_value);
                n_events++;
            end
            if (cfg_take) begin
                n_cfg++;
                case (i_cfg_index)
                    CFG_X_SPAN:     zone_cfg.x_span     = i_cfg_data;
                    CFG_X_LEFT_END: zone_cfg.x_left_end = i_cfg_data;
                    CFG_X_MID_LOW:  zone_cfg.x_mid_low  = i_cfg_data;
                    CFG_X_MID_HIGH: zone_cfg.x_mid_high = i_cfg_data;
                    CFG_Y_FLOOR:    zone_cfg.y_floor    = i_cfg_data;
                    default: ;
                endcase
            end
            if (!nv && !ncv && pend_q.size() > 0) begin
                case (pend_q[0].kind)
                    ENT_PHASE: begin
                        send_idle <= pend_q[0].send_pct;
                        recv_idle <= pend_q[0].recv_pct;
                        void'(pend_q.pop_front());
                    end
                    ENT_CFG: begin
                        // registers only change once every result is back
                        if (press_stage_q.size() == 0) begin
                            ncv   = 1'b1;
                            nidx  = pend_q[0].idx;
                            ndata = pend_q[0].data;
                            void'(pend_q.pop_front());
                        end
                    end
                    default: begin
                        if ($urandom_range(0, 99) >= send_idle) begin
                            nv    = 1'b1;
                            nmode = pend_q[0].mode;
                            nval  = pend_q[0].value;
                            void'(pend_q.pop_front());
                        end
                    end
                endcase
            end
        end
        i_valid     <= nv;
        i_mode      <= nmode;
        i_value     <= nval;
        i_cfg_valid <= ncv;
        i_cfg_index <= nidx;
        i_cfg_data  <= ndata;
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_res want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (press_stage_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result item with nothing pending, press %0b stage %0d",
                             $time, o_power_press, o_stage);
                end else begin
                    want = press_stage_q.pop_front();
                    n_results++;
                    if (o_power_press === 1'b1)
                        n_press++;
                    if (o_power_press !== want.power_press) begin
                        fail_cnt++;
                        $display("%0t: power_press mismatch, expected %0b actual %0b",
                                 $time, want.power_press, o_power_press);
                    end
                    if (o_stage !== want.stage) begin
                        fail_cnt++;
                        $display("%0t: stage mismatch, expected %0d actual %0d",
                                 $time, want.stage, o_stage);
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial begin : stim
        int   ph, k, z, i, n, x, y, rt, lft, target;
        t_ent ph_ent;

        // directed: full sweep, re-fire blocked, clears, field extremes, floor edge
        queue_event(MODE_TRACK, 16'd7);
        queue_event(MODE_X, 16'd1000);
        queue_event(MODE_Y, 16'd2000);
        queue_event(MODE_Y, 16'd2000);
        queue_event(MODE_X, 16'd600);
        queue_event(MODE_X, 16'd100);
        queue_event(MODE_Y, 16'd2000);
        queue_event(MODE_X, 16'd100);
        queue_event(MODE_Y, 16'd2000);
        queue_event(MODE_OTHER, 16'h5a5a);
        queue_event(MODE_TOP, 16'ha5a5);
        queue_event(MODE_TRACK, TRACK_RELEASE);
        queue_event(MODE_X, 16'h8000);
        queue_event(MODE_Y, 16'h7fff);
        queue_event(MODE_X, 16'h7fff);
        queue_event(MODE_Y, 16'hffff);
        queue_event(MODE_SLOT, 16'hffff);
        queue_event(MODE_X, 16'd1000);
        queue_event(MODE_Y, 16'd1800);
        queue_event(MODE_Y, 16'd1801);
        queue_event(MODE_X, 16'd1000);
        queue_event(MODE_SLOT, 16'h0000);
        queue_event(MODE_TRACK, 16'h7fff);

        for (ph = 0; ph < 3; ph++) begin
            ph_ent.kind     = ENT_PHASE;
            ph_ent.mode     = '0;
            ph_ent.value    = '0;
            ph_ent.idx      = '0;
            ph_ent.data     = '0;
            ph_ent.send_pct = (ph == 0) ? 28 : (ph == 1) ? 83 : 0;
            ph_ent.recv_pct = (ph == 0) ? 83 : (ph == 1) ? 28 : 0;
            pend_q.push_back(ph_ent);
            for (k = 0; k < 4; k++) begin
                if (k == 0 && ph == 0)
                    queue_cfg_set(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
                else if (k == 0 && ph == 1)
                    queue_cfg_set(12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
                else if (k == 0)
                    // span below left end: right zone edge negative
                    queue_cfg_set(12'd100, 12'd3000, 12'd2000, 12'd2500, 12'd500);
                else if (k == 1 && ph == 2)
                    queue_cfg_set(RST_X_SPAN, RST_X_LEFT_END, RST_X_MID_LOW, RST_X_MID_HIGH,
                                  RST_Y_FLOOR);
                else if (k == 3)
                    queue_cfg_set(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                                  12'($urandom));
                else begin
                    x  = $urandom_range(1200, 4095);
                    y  = $urandom_range(50, 400);
                    rt = $urandom_range(600, x - y - 100);
                    queue_cfg_set(12'(x), 12'(y), 12'($urandom_range(y + 10, rt - 10)), 12'(rt),
                                  12'($urandom_range(0, 3000)));
                end
                if ($urandom_range(0, 1))
                    queue_cfg(CFG_Y_FLOOR + 3'($urandom_range(1, 3)), 12'($urandom));

                target = ev_total + 70;
                while (ev_total < target) begin
                    if ($urandom_range(0, 99) < 75) begin
                        queue_event(MODE_TRACK, 16'($urandom_range(0, 32766)));
                        rt  = int'(plan_cfg.x_span) - int'(plan_cfg.x_left_end);
                        lft = (plan_cfg.x_mid_low < plan_cfg.x_left_end) ?
                              int'(plan_cfg.x_mid_low) : int'(plan_cfg.x_left_end);
                        // right zone, middle zone, far left, then a repeat after the press
                        for (z = 0; z < 4; z++) begin
                            n = (z == 3) ? $urandom_range(0, 1) : $urandom_range(1, 2);
                            for (i = 0; i < n; i++) begin
                                case (z)
                                    0: x = zone_pick(int'(plan_cfg.x_mid_high), rt);
                                    1: x = zone_pick(int'(plan_cfg.x_mid_low),
                                                     int'(plan_cfg.x_mid_high));
                                    default: x = lft - 1 - int'($urandom_range(0, 300));
                                endcase
                                y = int'(plan_cfg.y_floor) + 1 + int'($urandom_range(0, 1500));
                                if ($urandom_range(0, 99) < 10)
                                    x = int'($urandom_range(0, 4095));
                                if ($urandom_range(0, 99) < 10)
                                    y = int'($urandom_range(0, plan_cfg.y_floor));
                                if ($urandom_range(0, 1)) begin
                                    queue_event(MODE_X, 16'(x));
                                    queue_event(MODE_Y, 16'(y));
                                end else begin
                                    queue_event(MODE_Y, 16'(y));
                                    queue_event(MODE_X, 16'(x));
                                end
                            end
                        end
                        case ($urandom_range(0, 3))
                            0, 1: queue_event(MODE_TRACK, TRACK_RELEASE);
                            2: queue_event(MODE_SLOT, 16'($urandom));
                            default: ;
                        endcase
                    end else begin
                        queue_event(3'($urandom_range(0, 7)), 16'($urandom));
                    end
                end
            end
        end

        while (pend_q.size() != 0 || i_valid || i_cfg_valid || press_stage_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("covered %0d touch events and %0d register writes, %0d results checked",
                 n_events, n_cfg, n_results);
        $display("%0d key presses seen across three pacing phases", n_press);
        if (fail_cnt == 0 && press_stage_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
